>>> design/ctfc_pkg.sv
`timescale 1ns / 1ps

package ctfc_pkg;

  localparam int unsigned OSC_W      = 26;
  localparam int unsigned FACTOR_W   = 9;
  localparam int unsigned SYS_W      = OSC_W + FACTOR_W;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned PREDIV_W   = 4;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OSC_W-1:0]     OSC_RESET_HZ     = 26'd8000000;
  localparam logic [CFG_IDX_W-1:0] REG_INTERNAL_OSC = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_OSC = 4'd1;
  localparam logic [3:0]           LEGACY_FULL_LO   = 4'd15;
  localparam logic [FACTOR_W-1:0]  TIMES_SIX        = 9'd6;

  typedef enum logic [1:0] {
    SRC_INTERNAL = 2'd0,
    SRC_EXTERNAL = 2'd1,
    SRC_PLL      = 2'd2,
    SRC_OTHER    = 2'd3
  } src_e;

  typedef struct packed {
    logic [SHIFT_W-1:0] post_shift;
    logic [3:0]         ahb_code;
    logic [5:0]         apb_codes;
    logic [2:0]         adc_code;
  } code_t;

  typedef struct packed {
    logic [SYS_W-1:0] sys;
    logic [SYS_W-1:0] ahb;
    logic [SYS_W-1:0] apb1;
    logic [SYS_W-1:0] apb2;
    logic             sat;
  } clk_set_t;

  typedef struct packed {
    clk_set_t         clk;
    logic [SYS_W-1:0] adc;
  } result_t;

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    case (code)
      4'd8:    ahb_shift = 4'd1;
      4'd9:    ahb_shift = 4'd2;
      4'd10:   ahb_shift = 4'd3;
      4'd11:   ahb_shift = 4'd4;
      4'd12:   ahb_shift = 4'd6;
      4'd13:   ahb_shift = 4'd7;
      4'd14:   ahb_shift = 4'd8;
      4'd15:   ahb_shift = 4'd9;
      default: ahb_shift = 4'd0;
    endcase
  endfunction

  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    case (code)
      3'd4:    apb_shift = 3'd1;
      3'd5:    apb_shift = 3'd2;
      3'd6:    apb_shift = 3'd3;
      3'd7:    apb_shift = 3'd4;
      default: apb_shift = 3'd0;
    endcase
  endfunction

  // ADC divisor split into a power of two and an odd factor (1 or 3)
  function automatic logic [2:0] adc_shift(input logic [2:0] code);
    case (code)
      3'd0:    adc_shift = 3'd1;
      3'd1:    adc_shift = 3'd2;
      3'd2:    adc_shift = 3'd1;
      3'd3:    adc_shift = 3'd3;
      3'd4:    adc_shift = 3'd1;
      3'd5:    adc_shift = 3'd2;
      3'd6:    adc_shift = 3'd3;
      3'd7:    adc_shift = 3'd4;
      default: adc_shift = 3'd1;
    endcase
  endfunction

  function automatic logic [PREDIV_W-1:0] adc_odd(input logic [2:0] code);
    case (code)
      3'd2:    adc_odd = 4'd3;
      3'd5:    adc_odd = 4'd3;
      default: adc_odd = 4'd1;
    endcase
  endfunction

endpackage

>>> design/ctfc_source.sv
`timescale 1ns / 1ps

module ctfc_source (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [1:0]                          sysclk_source_i,
  input  logic                                internal_times_six_i,
  input  logic                                pll_from_external_i,
  input  logic                                external_halved_i,
  input  logic                                pll_new_mode_i,
  input  logic [5:0]                          mult_code_i,
  input  logic [3:0]                          pll_pre_div_i,
  input  logic [8:0]                          pll_loop_mult_i,
  input  logic [2:0]                          pll_post_shift_i,
  input  logic [3:0]                          ahb_div_code_i,
  input  logic [5:0]                          apb_div_codes_i,
  input  logic [2:0]                          adc_div_code_i,
  input  logic [ctfc_pkg::OSC_W-1:0]          internal_osc_i,
  input  logic [ctfc_pkg::OSC_W-1:0]          external_osc_i,
  output logic                                valid_o,
  output logic [ctfc_pkg::SYS_W-1:0]          product_o,
  output logic [ctfc_pkg::PREDIV_W-1:0]       pre_div_o,
  output ctfc_pkg::code_t                     code_o
);

  logic [ctfc_pkg::OSC_W-1:0]    base_d, base_q, pll_ref;
  logic [ctfc_pkg::FACTOR_W-1:0] factor_d, factor_q, legacy_mult;
  logic [ctfc_pkg::PREDIV_W-1:0] div_d, div_q, div2_q;
  ctfc_pkg::code_t               code_d, code_q, code2_q;
  logic [ctfc_pkg::SYS_W-1:0]    product_d, product_q;
  logic                          valid1_q, valid2_q;

  // low nibble plus sixteen times high part equals the code itself
  always_comb begin
    if (mult_code_i[5:4] != 2'd0 || mult_code_i[3:0] == ctfc_pkg::LEGACY_FULL_LO) begin
      legacy_mult = ctfc_pkg::FACTOR_W'(mult_code_i) + 9'd1;
    end else begin
      legacy_mult = ctfc_pkg::FACTOR_W'(mult_code_i) + 9'd2;
    end
  end

  always_comb begin
    if (!pll_from_external_i) begin
      pll_ref = internal_osc_i >> 1;
    end else if (external_halved_i) begin
      pll_ref = external_osc_i >> 1;
    end else begin
      pll_ref = external_osc_i;
    end
  end

  always_comb begin
    div_d               = 4'd1;
    code_d.post_shift   = '0;
    code_d.ahb_code     = ahb_div_code_i;
    code_d.apb_codes    = apb_div_codes_i;
    code_d.adc_code     = adc_div_code_i;
    case (sysclk_source_i)
      ctfc_pkg::SRC_EXTERNAL: begin
        base_d   = external_osc_i;
        factor_d = 9'd1;
      end
      ctfc_pkg::SRC_PLL: begin
        base_d = pll_ref;
        if (pll_new_mode_i) begin
          factor_d          = pll_loop_mult_i;
          div_d             = (pll_pre_div_i == 4'd0) ? 4'd1 : pll_pre_div_i;
          code_d.post_shift = pll_post_shift_i;
        end else begin
          factor_d = legacy_mult;
        end
      end
      default: begin
        base_d = internal_osc_i;
        if (internal_times_six_i && sysclk_source_i == ctfc_pkg::SRC_INTERNAL) begin
          factor_d = ctfc_pkg::TIMES_SIX;
        end else begin
          factor_d = 9'd1;
        end
      end
    endcase
  end

  assign product_d = base_q * factor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q    <= base_d;
      factor_q  <= factor_d;
      div_q     <= div_d;
      code_q    <= code_d;
      product_q <= product_d;
      div2_q    <= div_q;
      code2_q   <= code_q;
    end
  end

  assign valid_o   = valid2_q;
  assign product_o = product_q;
  assign pre_div_o = div2_q;
  assign code_o    = code2_q;

endmodule

>>> design/ctfc_divider.sv
`timescale 1ns / 1ps

module ctfc_divider #(
  parameter int unsigned DIVIDEND_W      = 35,
  parameter int unsigned DIVISOR_W       = 4,
  parameter int unsigned STEPS_PER_STAGE = 7,
  parameter int unsigned SIDE_W          = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned NUM_STAGES = (DIVIDEND_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned WORK_W     = NUM_STAGES * STEPS_PER_STAGE;
  localparam int unsigned LAST       = NUM_STAGES - 1;

  // work register shifts dividend bits out the top and quotient bits in the bottom
  logic [WORK_W-1:0]    work_in [NUM_STAGES];
  logic [WORK_W-1:0]    work_d  [NUM_STAGES];
  logic [WORK_W-1:0]    work_q  [NUM_STAGES];
  logic [DIVISOR_W-1:0] rem_in  [NUM_STAGES];
  logic [DIVISOR_W-1:0] rem_d   [NUM_STAGES];
  logic [DIVISOR_W-1:0] rem_q   [NUM_STAGES];
  logic [DIVISOR_W-1:0] div_in  [NUM_STAGES];
  logic [DIVISOR_W-1:0] div_q   [NUM_STAGES];
  logic [SIDE_W-1:0]    side_in [NUM_STAGES];
  logic [SIDE_W-1:0]    side_q  [NUM_STAGES];
  logic [NUM_STAGES-1:0] valid_in, valid_q;

  always_comb begin
    logic [WORK_W-1:0]    w;
    logic [DIVISOR_W-1:0] r;
    logic [DIVISOR_W:0]   trial;
    work_in[0]  = WORK_W'(dividend_i);
    rem_in[0]   = '0;
    div_in[0]   = divisor_i;
    side_in[0]  = side_i;
    valid_in[0] = valid_i;
    for (int s = 1; s < NUM_STAGES; s++) begin
      work_in[s]  = work_q[s-1];
      rem_in[s]   = rem_q[s-1];
      div_in[s]   = div_q[s-1];
      side_in[s]  = side_q[s-1];
      valid_in[s] = valid_q[s-1];
    end
    for (int s = 0; s < NUM_STAGES; s++) begin
      w = work_in[s];
      r = rem_in[s];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        trial = {r, w[WORK_W-1]};
        w     = {w[WORK_W-2:0], 1'b0};
        if (trial >= {1'b0, div_in[s]}) begin
          trial = trial - {1'b0, div_in[s]};
          w[0]  = 1'b1;
        end
        r = trial[DIVISOR_W-1:0];
      end
      work_d[s] = w;
      rem_d[s]  = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        work_q[s] <= work_d[s];
        rem_q[s]  <= rem_d[s];
        div_q[s]  <= div_in[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o    = valid_q[LAST];
  assign quotient_o = work_q[LAST][DIVIDEND_W-1:0];
  assign side_o     = side_q[LAST];

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LAST] && div_q[LAST] != '0 |-> rem_q[LAST] < div_q[LAST])
    else $error("divider remainder not below divisor");

endmodule

>>> design/ctfc_bus.sv
`timescale 1ns / 1ps

module ctfc_bus #(
  parameter int unsigned FREQ_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ctfc_pkg::SYS_W-1:0]    quotient_i,
  input  ctfc_pkg::code_t               code_i,
  output logic                          valid_o,
  output logic [ctfc_pkg::SYS_W-1:0]    dividend_o,
  output logic [ctfc_pkg::PREDIV_W-1:0] divisor_o,
  output ctfc_pkg::clk_set_t            clk_o
);

  localparam int unsigned SAT_W =
    (FREQ_WIDTH < ctfc_pkg::SYS_W) ? FREQ_WIDTH : ctfc_pkg::SYS_W;
  localparam logic [ctfc_pkg::SYS_W-1:0] SAT_VALUE =
    ~({ctfc_pkg::SYS_W{1'b1}} << SAT_W);

  logic [ctfc_pkg::SYS_W-1:0]    shifted, sys_d, sys_q;
  logic                          over, sat_q;
  ctfc_pkg::code_t               code_q;
  logic                          valid_a_q, valid_b_q;
  ctfc_pkg::clk_set_t            clk_d, clk_q;
  logic [ctfc_pkg::SYS_W-1:0]    adc_pre_d, adc_pre_q;
  logic [ctfc_pkg::PREDIV_W-1:0] odd_d, odd_q;

  // post divider, then clamp to the frequency width
  assign shifted = quotient_i >> code_i.post_shift;
  assign over    = |(shifted & ~SAT_VALUE);
  assign sys_d   = over ? SAT_VALUE : shifted;

  always_comb begin
    clk_d.sys  = sys_q;
    clk_d.sat  = sat_q;
    clk_d.ahb  = sys_q >> ctfc_pkg::ahb_shift(code_q.ahb_code);
    clk_d.apb1 = clk_d.ahb >> ctfc_pkg::apb_shift(code_q.apb_codes[2:0]);
    clk_d.apb2 = clk_d.ahb >> ctfc_pkg::apb_shift(code_q.apb_codes[5:3]);
    adc_pre_d  = clk_d.apb2 >> ctfc_pkg::adc_shift(code_q.adc_code);
    odd_d      = ctfc_pkg::adc_odd(code_q.adc_code);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sys_q     <= sys_d;
      sat_q     <= over;
      code_q    <= code_i;
      clk_q     <= clk_d;
      adc_pre_q <= adc_pre_d;
      odd_q     <= odd_d;
    end
  end

  assign valid_o    = valid_b_q;
  assign dividend_o = adc_pre_q;
  assign divisor_o  = odd_q;
  assign clk_o      = clk_q;

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_b_q && clk_q.sat |-> clk_q.sys == SAT_VALUE)
    else $error("saturated system clock not at limit");

  a_bus_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_b_q |-> clk_q.ahb <= clk_q.sys && clk_q.apb1 <= clk_q.ahb
                  && clk_q.apb2 <= clk_q.ahb)
    else $error("bus clock above its parent");

endmodule

>>> design/ctfc_skid.sv
`timescale 1ns / 1ps

module ctfc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ctfc_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output ctfc_pkg::result_t data_o
);

  logic              out_valid_q, skid_valid_q;
  ctfc_pkg::result_t out_q, skid_q;
  logic              hold;

  assign hold = out_valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (hold) begin
      if (valid_i && !skid_valid_q) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold) begin
      if (!skid_valid_q) begin
        skid_q <= data_i;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= data_i;
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat held with empty output register");

endmodule

>>> design/clock_tree_frequency_calc.sv
`timescale 1ns / 1ps

// Clock-tree frequency calculator.
// Input channel (in_valid_i / in_stall_o) carries one snapshot of the clock
// settings per beat; the output channel (out_valid_o / out_stall_i) returns
// the system, AHB, APB1, APB2 and ADC frequencies plus a saturation flag.
// Oscillator frequencies are set through the cfg write port (index 0 internal,
// index 1 external, 26 data bits kept); cfg_ready_o is always high. Write them
// only while no beat is in flight.
// Throughput: one beat per cycle while in_stall_o is low. The depth comes
// from two pipelined restoring dividers (PLL pre-divider, ADC odd factor) at
// seven quotient bits per stage, plus the source select, the multiplier and
// two bus stages.
// Reset clears all valid bits and loads 8 MHz into both oscillator registers.
// When the receiver stalls, the output beat holds and one more beat lands in a
// skid register; then in_stall_o rises and the whole pipeline freezes until
// the output drains, so nothing is lost or repeated.
module clock_tree_frequency_calc #(
  parameter int unsigned FREQ_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ctfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ctfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      sysclk_source_i,
  input  logic                            internal_times_six_i,
  input  logic                            pll_from_external_i,
  input  logic                            external_halved_i,
  input  logic                            pll_new_mode_i,
  input  logic [5:0]                      mult_code_i,
  input  logic [3:0]                      pll_pre_div_i,
  input  logic [8:0]                      pll_loop_mult_i,
  input  logic [2:0]                      pll_post_shift_i,
  input  logic [3:0]                      ahb_div_code_i,
  input  logic [5:0]                      apb_div_codes_i,
  input  logic [2:0]                      adc_div_code_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [31:0]                     sys_hz_o,
  output logic [31:0]                     ahb_hz_o,
  output logic [31:0]                     apb1_hz_o,
  output logic [31:0]                     apb2_hz_o,
  output logic [31:0]                     adc_hz_o,
  output logic                            sys_saturated_o
);

  localparam int unsigned CODE_W = $bits(ctfc_pkg::code_t);
  localparam int unsigned CLK_W  = $bits(ctfc_pkg::clk_set_t);

  logic [ctfc_pkg::OSC_W-1:0]    internal_osc_q, external_osc_q;
  logic                          cfg_write;
  logic                          adv, skid_full;

  logic                          src_valid;
  logic [ctfc_pkg::SYS_W-1:0]    src_product;
  logic [ctfc_pkg::PREDIV_W-1:0] src_pre_div;
  ctfc_pkg::code_t               src_code;

  logic                          div1_valid;
  logic [ctfc_pkg::SYS_W-1:0]    div1_quotient;
  logic [CODE_W-1:0]             div1_side;

  logic                          bus_valid;
  logic [ctfc_pkg::SYS_W-1:0]    bus_dividend;
  logic [ctfc_pkg::PREDIV_W-1:0] bus_divisor;
  ctfc_pkg::clk_set_t            bus_clk;

  logic                          div2_valid;
  logic [ctfc_pkg::SYS_W-1:0]    div2_quotient;
  logic [CLK_W-1:0]              div2_side;

  ctfc_pkg::result_t             res, out_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      internal_osc_q <= ctfc_pkg::OSC_RESET_HZ;
      external_osc_q <= ctfc_pkg::OSC_RESET_HZ;
    end else if (cfg_write) begin
      if (cfg_index_i == ctfc_pkg::REG_INTERNAL_OSC) begin
        internal_osc_q <= cfg_data_i[ctfc_pkg::OSC_W-1:0];
      end else if (cfg_index_i == ctfc_pkg::REG_EXTERNAL_OSC) begin
        external_osc_q <= cfg_data_i[ctfc_pkg::OSC_W-1:0];
      end
    end
  end

  // freeze every stage ahead of the skid register while it holds a beat
  assign adv        = !skid_full;
  assign in_stall_o = skid_full;

  ctfc_source u_source (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .en_i                 (adv),
    .valid_i              (in_valid_i),
    .sysclk_source_i      (sysclk_source_i),
    .internal_times_six_i (internal_times_six_i),
    .pll_from_external_i  (pll_from_external_i),
    .external_halved_i    (external_halved_i),
    .pll_new_mode_i       (pll_new_mode_i),
    .mult_code_i          (mult_code_i),
    .pll_pre_div_i        (pll_pre_div_i),
    .pll_loop_mult_i      (pll_loop_mult_i),
    .pll_post_shift_i     (pll_post_shift_i),
    .ahb_div_code_i       (ahb_div_code_i),
    .apb_div_codes_i      (apb_div_codes_i),
    .adc_div_code_i       (adc_div_code_i),
    .internal_osc_i       (internal_osc_q),
    .external_osc_i       (external_osc_q),
    .valid_o              (src_valid),
    .product_o            (src_product),
    .pre_div_o            (src_pre_div),
    .code_o               (src_code)
  );

  ctfc_divider #(
    .DIVIDEND_W      (ctfc_pkg::SYS_W),
    .DIVISOR_W       (ctfc_pkg::PREDIV_W),
    .STEPS_PER_STAGE (7),
    .SIDE_W          (CODE_W)
  ) u_pll_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (src_valid),
    .dividend_i (src_product),
    .divisor_i  (src_pre_div),
    .side_i     (src_code),
    .valid_o    (div1_valid),
    .quotient_o (div1_quotient),
    .side_o     (div1_side)
  );

  ctfc_bus #(
    .FREQ_WIDTH (FREQ_WIDTH)
  ) u_bus (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (div1_valid),
    .quotient_i (div1_quotient),
    .code_i     (ctfc_pkg::code_t'(div1_side)),
    .valid_o    (bus_valid),
    .dividend_o (bus_dividend),
    .divisor_o  (bus_divisor),
    .clk_o      (bus_clk)
  );

  ctfc_divider #(
    .DIVIDEND_W      (ctfc_pkg::SYS_W),
    .DIVISOR_W       (ctfc_pkg::PREDIV_W),
    .STEPS_PER_STAGE (7),
    .SIDE_W          (CLK_W)
  ) u_adc_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (bus_valid),
    .dividend_i (bus_dividend),
    .divisor_i  (bus_divisor),
    .side_i     (bus_clk),
    .valid_o    (div2_valid),
    .quotient_o (div2_quotient),
    .side_o     (div2_side)
  );

  assign res.clk = ctfc_pkg::clk_set_t'(div2_side);
  assign res.adc = div2_quotient;

  ctfc_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div2_valid),
    .data_i  (res),
    .full_o  (skid_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign sys_hz_o        = out_res.clk.sys[ctfc_pkg::OUT_W-1:0];
  assign ahb_hz_o        = out_res.clk.ahb[ctfc_pkg::OUT_W-1:0];
  assign apb1_hz_o       = out_res.clk.apb1[ctfc_pkg::OUT_W-1:0];
  assign apb2_hz_o       = out_res.clk.apb2[ctfc_pkg::OUT_W-1:0];
  assign adc_hz_o        = out_res.adc[ctfc_pkg::OUT_W-1:0];
  assign sys_saturated_o = out_res.clk.sat;

endmodule

>>> tb/sv/clock_tree_frequency_calc_test.sv
`timescale 1ns / 1ps

module clock_tree_frequency_calc_test;
  import ctfc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 222;

  localparam int unsigned AHB_SHIFT_TAB [16] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3, 4, 6, 7, 8, 9};
  localparam int unsigned APB_SHIFT_TAB [8]  = '{0, 0, 0, 0, 1, 2, 3, 4};
  localparam int unsigned ADC_DIV_TAB [8]    = '{2, 4, 6, 8, 2, 12, 8, 16};

  typedef struct packed {
    src_e       src;
    logic       times_six;
    logic       pll_ext;
    logic       ext_halved;
    logic       new_mode;
    logic [5:0] mult_code;
    logic [3:0] pre_div;
    logic [8:0] loop_mult;
    logic [2:0] post_shift;
    logic [3:0] ahb_code;
    logic [5:0] apb_codes;
    logic [2:0] adc_code;
  } snapshot_t;

  typedef struct packed {
    logic [31:0] sys;
    logic [31:0] ahb;
    logic [31:0] apb1;
    logic [31:0] apb2;
    logic [31:0] adc;
    logic        sat;
  } freqs_t;

  class freq_scoreboard;
    logic [OSC_W-1:0] int_osc_hz;
    logic [OSC_W-1:0] ext_osc_hz;
    freqs_t           expected_freqs[$];
    int unsigned      errors;

    function new();
      int_osc_hz = OSC_RESET_HZ;
      ext_osc_hz = OSC_RESET_HZ;
      errors     = 0;
    endfunction

    function void write_osc(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_INTERNAL_OSC) begin
        int_osc_hz = data[OSC_W-1:0];
      end else if (idx == REG_EXTERNAL_OSC) begin
        ext_osc_hz = data[OSC_W-1:0];
      end
    endfunction

    function freqs_t compute_freqs(snapshot_t s);
      logic [63:0] ref_hz;
      logic [63:0] mult;
      logic [63:0] div;
      logic [63:0] sys;
      logic [63:0] ahb;
      logic [63:0] apb2;
      freqs_t      f;
      f = '0;
      if (!s.pll_ext) begin
        ref_hz = 64'(int_osc_hz >> 1);
      end else if (s.ext_halved) begin
        ref_hz = 64'(ext_osc_hz >> 1);
      end else begin
        ref_hz = 64'(ext_osc_hz);
      end
      case (s.src)
        SRC_EXTERNAL: sys = 64'(ext_osc_hz);
        SRC_PLL: begin
          if (!s.new_mode) begin
            if (s.mult_code[5:4] != 2'd0 || s.mult_code[3:0] == LEGACY_FULL_LO) begin
              mult = 64'(s.mult_code) + 64'd1;
            end else begin
              mult = 64'(s.mult_code[3:0]) + 64'd2;
            end
            sys = ref_hz * mult;
          end else begin
            // a zero pre-divider counts as one
            div = 64'((s.pre_div == 4'd0) ? 4'd1 : s.pre_div) << s.post_shift;
            sys = (ref_hz * 64'(s.loop_mult)) / div;
          end
        end
        SRC_INTERNAL: sys = s.times_six ? 64'(int_osc_hz) * 64'd6 : 64'(int_osc_hz);
        default: sys = 64'(int_osc_hz);
      endcase
      if (sys > 64'hFFFF_FFFF) begin
        sys   = 64'hFFFF_FFFF;
        f.sat = 1'b1;
      end
      ahb    = sys >> AHB_SHIFT_TAB[s.ahb_code];
      apb2   = ahb >> APB_SHIFT_TAB[s.apb_codes[5:3]];
      f.sys  = sys[31:0];
      f.ahb  = ahb[31:0];
      f.apb1 = 32'(ahb >> APB_SHIFT_TAB[s.apb_codes[2:0]]);
      f.apb2 = apb2[31:0];
      f.adc  = 32'(apb2 / 64'(ADC_DIV_TAB[s.adc_code]));
      return f;
    endfunction

    function void note_snapshot(snapshot_t s);
      expected_freqs.push_back(compute_freqs(s));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(freqs_t got);
      freqs_t want;
      if (expected_freqs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none pending, expected nothing got sys_hz %0d",
                   $time, got.sys);
        return;
      end
      want = expected_freqs.pop_front();
      compare_field("sys_hz", want.sys, got.sys);
      compare_field("ahb_hz", want.ahb, got.ahb);
      compare_field("apb1_hz", want.apb1, got.apb1);
      compare_field("apb2_hz", want.apb2, got.apb2);
      compare_field("adc_hz", want.adc, got.adc);
      compare_field("sys_saturated", 32'(want.sat), 32'(got.sat));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            sysclk_source_i;
  logic                  internal_times_six_i;
  logic                  pll_from_external_i;
  logic                  external_halved_i;
  logic                  pll_new_mode_i;
  logic [5:0]            mult_code_i;
  logic [3:0]            pll_pre_div_i;
  logic [8:0]            pll_loop_mult_i;
  logic [2:0]            pll_post_shift_i;
  logic [3:0]            ahb_div_code_i;
  logic [5:0]            apb_div_codes_i;
  logic [2:0]            adc_div_code_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [31:0]           sys_hz_o;
  logic [31:0]           ahb_hz_o;
  logic [31:0]           apb1_hz_o;
  logic [31:0]           apb2_hz_o;
  logic [31:0]           adc_hz_o;
  logic                  sys_saturated_o;

  freq_scoreboard sb;
  bit             burst_feed;
  int unsigned    cycle_count = 0;

  clock_tree_frequency_calc dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({sys_hz_o, ahb_hz_o, apb1_hz_o, apb2_hz_o, adc_hz_o, sys_saturated_o});
  end

  initial begin : receiver
    int unsigned seg;
    int unsigned roll;
    seg = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      seg++;
      roll = $urandom_range(23);
      if (seg % 120 == 40 || roll == 0) begin
        // hold off long enough to fill the pipeline and back up the input
        out_stall_i <= 1'b1;
        repeat ($urandom_range(80, 40)) @(posedge clk_i);
      end else if (roll < 6) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(60, 20)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_feed) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic snapshot_t rand_snapshot();
    snapshot_t   s;
    int unsigned roll;
    roll         = $urandom_range(99);
    s.src        = src_e'($urandom_range(3));
    s.times_six  = 1'($urandom_range(1));
    s.pll_ext    = 1'($urandom_range(1));
    s.ext_halved = 1'($urandom_range(1));
    s.new_mode   = 1'($urandom_range(1));
    s.mult_code  = 6'($urandom_range(63));
    s.pre_div    = 4'($urandom_range(15));
    s.loop_mult  = ($urandom_range(9) < 3) ? 9'($urandom_range(511)) : 9'($urandom_range(500, 31));
    s.post_shift = 3'($urandom_range(7));
    s.ahb_code   = 4'($urandom_range(15));
    s.apb_codes  = 6'($urandom_range(63));
    s.adc_code   = 3'($urandom_range(7));
    if (roll < 45) s.src = SRC_PLL;
    if (roll < 12) begin
      // push the pll product toward the 32-bit ceiling
      s.new_mode   = 1'b1;
      s.pll_ext    = 1'b1;
      s.ext_halved = 1'b0;
      s.pre_div    = 4'($urandom_range(2));
      s.post_shift = 3'($urandom_range(1));
      s.loop_mult  = 9'($urandom_range(511, 400));
    end
    return s;
  endfunction

  task automatic offer_snapshot(input snapshot_t s);
    int unsigned gap;
    in_valid_i           <= 1'b1;
    sysclk_source_i      <= s.src;
    internal_times_six_i <= s.times_six;
    pll_from_external_i  <= s.pll_ext;
    external_halved_i    <= s.ext_halved;
    pll_new_mode_i       <= s.new_mode;
    mult_code_i          <= s.mult_code;
    pll_pre_div_i        <= s.pre_div;
    pll_loop_mult_i      <= s.loop_mult;
    pll_post_shift_i     <= s.post_shift;
    ahb_div_code_i       <= s.ahb_code;
    apb_div_codes_i      <= s.apb_codes;
    adc_div_code_i       <= s.adc_code;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_snapshot(s);
    gap = pick_gap();
    // with no gap, keep valid up for the next beat
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_freqs.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_osc(input logic [CFG_DATA_W-1:0] int_data,
                             input logic [CFG_DATA_W-1:0] ext_data, input bit stray);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx[0] = REG_INTERNAL_OSC;
    val[0] = int_data;
    // unmapped index: must leave both oscillators alone
    idx[1] = CFG_IDX_W'($urandom_range(15, 2));
    val[1] = $urandom();
    idx[2] = REG_EXTERNAL_OSC;
    val[2] = ext_data;
    wait_drained();
    for (int k = 0; k < 3; k++) begin
      if (k != 1 || stray) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= idx[k];
        cfg_data_i  <= val[k];
        do @(posedge clk_i); while (!cfg_ready_o);
        sb.write_osc(idx[k], val[k]);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    snapshot_t s;
    sb = new();
    burst_feed           = 1'b0;
    rst_ni               <= 1'b0;
    cfg_valid_i          <= 1'b0;
    cfg_index_i          <= '0;
    cfg_data_i           <= '0;
    in_valid_i           <= 1'b0;
    sysclk_source_i      <= '0;
    internal_times_six_i <= 1'b0;
    pll_from_external_i  <= 1'b0;
    external_halved_i    <= 1'b0;
    pll_new_mode_i       <= 1'b0;
    mult_code_i          <= '0;
    pll_pre_div_i        <= '0;
    pll_loop_mult_i      <= '0;
    pll_post_shift_i     <= '0;
    ahb_div_code_i       <= '0;
    apb_div_codes_i      <= '0;
    adc_div_code_i       <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: program_osc(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        2: program_osc(32'd1_000_000, 32'd50_000_000, 1'b1);
        3: program_osc(32'd50_000_000, 32'd1_000_000, 1'b0);
        4: program_osc(32'h0400_0000, 32'd1, 1'b1);
        5: program_osc($urandom_range(50_000_000, 1_000_000),
                       $urandom_range(50_000_000, 1_000_000), 1'b1);
        6: program_osc($urandom(), $urandom(), 1'b1);
        default: ;
      endcase

      if (ph == 0) begin
        s = '0;
        s.src = SRC_INTERNAL;
        offer_snapshot(s);
        s.times_six = 1'b1;
        offer_snapshot(s);
        // source code three ignores the times-six bit
        s.src = SRC_OTHER;
        offer_snapshot(s);
        s.src       = SRC_EXTERNAL;
        s.ahb_code  = 4'd15;
        s.apb_codes = 6'd63;
        s.adc_code  = 3'd7;
        offer_snapshot(s);
        s.src       = SRC_PLL;
        s.ahb_code  = 4'd0;
        s.apb_codes = 6'd0;
        s.adc_code  = 3'd0;
        s.mult_code = 6'd0;
        offer_snapshot(s);
        s.mult_code = 6'd14;
        offer_snapshot(s);
        s.mult_code = 6'd15;
        offer_snapshot(s);
        s.mult_code = 6'd16;
        offer_snapshot(s);
        s.pll_ext   = 1'b1;
        s.mult_code = 6'd63;
        offer_snapshot(s);
        s.ext_halved = 1'b1;
        s.mult_code  = 6'd37;
        offer_snapshot(s);
        s.new_mode   = 1'b1;
        s.ext_halved = 1'b0;
        s.pre_div    = 4'd0;
        s.loop_mult  = 9'd511;
        s.post_shift = 3'd0;
        offer_snapshot(s);
        s.pre_div    = 4'd15;
        s.loop_mult  = 9'd31;
        s.post_shift = 3'd7;
        offer_snapshot(s);
        s.loop_mult = 9'd0;
        offer_snapshot(s);
        s.pll_ext    = 1'b0;
        s.pre_div    = 4'd1;
        s.loop_mult  = 9'd500;
        s.post_shift = 3'd0;
        offer_snapshot(s);
        // sweep the bus and adc tables
        for (int c = 0; c < 8; c++) begin
          s.ahb_code  = 4'(c + 8);
          s.apb_codes = 6'(c * 9);
          s.adc_code  = 3'(c);
          offer_snapshot(s);
        end
      end else if (ph == 1) begin
        s = '0;
        s.src       = SRC_PLL;
        s.new_mode  = 1'b1;
        s.pll_ext   = 1'b1;
        s.pre_div   = 4'd1;
        s.loop_mult = 9'd511;
        // saturated, saturated, just under the ceiling
        for (int fr = 0; fr < 4; fr += 2) begin
          s.post_shift = 3'(fr);
          offer_snapshot(s);
        end
        s.post_shift = 3'd3;
        offer_snapshot(s);
      end

      burst_feed = (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_drained();
        offer_snapshot(rand_snapshot());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_freqs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
